/* rtl/hill37_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill37_pkg
// Shared types, constants and symbol mapping for the mod-37 Hill encryptor.
// ----------------------------------------------------------------------------
package hill37_pkg;

   // Geometry
   localparam int MAX_DIM = 7;
   localparam int SYM_W   = 6;
   localparam int ROW_W   = 3;
   localparam int DIM_W   = 3;
   localparam int KEY_W   = MAX_DIM * SYM_W;
   // worst case sum: MAX_DIM * 63 * 36 = 15876
   localparam int ACC_W   = 14;
   localparam int CHR_W   = 8;
   localparam int IDX_W   = 3;

   // Alphabet
   localparam logic [SYM_W-1:0] ALPHA       = 6'd37;
   localparam logic [SYM_W-1:0] SPACE_SYM   = 6'd36;
   localparam logic [SYM_W-1:0] SYM_DIGIT0  = 6'd26;
   localparam logic [CHR_W-1:0] CHR_A       = 8'h41;
   localparam logic [CHR_W-1:0] CHR_Z       = 8'h5A;
   localparam logic [CHR_W-1:0] CHR_ZERO    = 8'h30;
   localparam logic [CHR_W-1:0] CHR_NINE    = 8'h39;
   localparam logic [CHR_W-1:0] CHR_SPACE   = 8'h20;

   // Reciprocal of 37 for sums below 2**ACC_W: q = (x * RECIP_MUL) >> RECIP_SHIFT
   localparam int RECIP_W     = 15;
   localparam int RECIP_SHIFT = 20;
   localparam int QUOT_W      = 9;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 15'd28340;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_BLOCK_SIZE = 3'd0;
   localparam logic [IDX_W-1:0] CSR_KEY_ROW0   = 3'd1;

   typedef struct packed {
      logic [CHR_W-1:0] char_code;
      logic             flush;
   } req_type;

   typedef struct packed {
      logic [CHR_W-1:0] cipher_char;
      logic             block_last;
   } rsp_type;

   // Partial sum travelling down the cell row
   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
      logic [ACC_W-1:0] acc;
   } link_type;

   // Reduced row result
   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
      logic [SYM_W-1:0] sym;
   } res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPUTE,
      ST_DRAIN
   } state_type;

   function automatic logic [SYM_W-1:0] sym_of_byte(input logic [CHR_W-1:0] c);
      logic [CHR_W-1:0] d;
      d = '0;
      if (c inside {[CHR_A:CHR_Z]}) begin
         d = c - CHR_A;
         return d[SYM_W-1:0];
      end
      if (c inside {[CHR_ZERO:CHR_NINE]}) begin
         d = c - CHR_ZERO;
         return d[SYM_W-1:0] + SYM_DIGIT0;
      end
      if (c == CHR_SPACE) begin
         return SPACE_SYM;
      end
      return '0;
   endfunction

   function automatic logic [CHR_W-1:0] byte_of_sym(input logic [SYM_W-1:0] v);
      if (v < SYM_DIGIT0) begin
         return CHR_A + CHR_W'(v);
      end
      if (v < SPACE_SYM) begin
         return CHR_ZERO + CHR_W'(v - SYM_DIGIT0);
      end
      return CHR_SPACE;
   endfunction

   // Effective dimension: zero counts as one
   function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] bs);
      return (bs == '0) ? DIM_W'(1) : bs;
   endfunction

endpackage

/* rtl/hill37_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill37_cell
// One column of the key product: holds one block symbol, adds key*symbol
// into the partial sum passing by, and hands the sum to the next cell.
// ----------------------------------------------------------------------------
module hill37_cell (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                col_en,
   input  logic                                                load_en,
   input  logic                                                clear_en,
   input  logic [hill37_pkg::SYM_W-1:0]                        load_sym,
   input  logic [hill37_pkg::MAX_DIM-1:0][hill37_pkg::SYM_W-1:0] key_col,
   input  hill37_pkg::link_type                                link_in,
   output hill37_pkg::link_type                                link_out
);
   import hill37_pkg::*;

   logic [SYM_W-1:0]   sym_ff;
   logic [SYM_W-1:0]   sym_in;
   link_type           link_ff;
   link_type           link_next_in;
   logic [2*SYM_W-1:0] prod;

   // Symbol slot: load on fill, back to space after a block leaves
   always_comb begin
      sym_in = sym_ff;
      if (clear_en) begin
         sym_in = SPACE_SYM;
      end else if (load_en) begin
         sym_in = load_sym;
      end
   end

   // Key entry of this column for the row passing by; columns beyond n are off
   assign prod = col_en ? key_col[link_in.row] * sym_ff : '0;

   always_comb begin
      link_next_in       = link_in;
      link_next_in.acc   = link_in.acc + ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff        <= SPACE_SYM;
         link_ff.valid <= 1'b0;
      end else begin
         sym_ff        <= sym_in;
         link_ff.valid <= link_next_in.valid;
      end
      link_ff.row <= link_next_in.row;
      link_ff.acc <= link_next_in.acc;
   end

   assign link_out = link_ff;

endmodule

/* rtl/hill37_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill37_reduce
// Reduces a finished row sum modulo 37: reciprocal multiply into a register,
// then subtract quotient times 37.
// ----------------------------------------------------------------------------
module hill37_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  hill37_pkg::link_type sum_in,
   output hill37_pkg::res_type  res_out
);
   import hill37_pkg::*;

   localparam int PROD_W = ACC_W + RECIP_W;

   logic             valid_ff;
   logic [ROW_W-1:0] row_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [QUOT_W-1:0] quot_in;
   logic [PROD_W-1:0] recip_prod;
   logic [ACC_W-1:0]  rem;

   // Quotient estimate, exact for sums below 2**ACC_W
   assign recip_prod = PROD_W'(sum_in.acc) * PROD_W'(RECIP_MUL);
   assign quot_in    = recip_prod[RECIP_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sum_in.valid;
      end
      row_ff  <= sum_in.row;
      acc_ff  <= sum_in.acc;
      quot_ff <= quot_in;
   end

   // Remainder is below 37
   assign rem = acc_ff - ACC_W'(quot_ff) * ACC_W'(ALPHA);

   assign res_out.valid = valid_ff;
   assign res_out.row   = row_ff;
   assign res_out.sym   = rem[SYM_W-1:0];

endmodule

/* rtl/hill_cipher_mod37_encryptor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_mod37_encryptor_top
// Hill encryptor over a 37-symbol alphabet: symbols fill a row of cells, and
// partial sums of each key row flow through the cells to a mod-37 stage.
// ----------------------------------------------------------------------------
// A beat that does not complete a block is taken while the encryptor idles.
// A completing beat (block full, or flush of a non-empty block) starts n row
// sums down the 7-cell row; each sum passes the cell and reduce registers
// into the result store, then the n result beats leave one per cycle while
// the receiver is ready. No beat is taken until the last result is loaded.
// Synchronous reset: block size 1, key zero, buffer all spaces, nothing held.
// ----------------------------------------------------------------------------
module hill_cipher_mod37_encryptor_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  hill37_pkg::req_type           req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output hill37_pkg::rsp_type           rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hill37_pkg::IDX_W-1:0]  csr_index,
   input  logic [hill37_pkg::KEY_W-1:0]  csr_data
);
   import hill37_pkg::*;

   // Configuration
   logic [DIM_W-1:0] bsize_ff;
   logic [KEY_W-1:0] key_ff [MAX_DIM];
   logic [DIM_W-1:0] dim;
   logic [DIM_W-1:0] dim_m1;
   logic [IDX_W-1:0] key_sel;

   // Control
   state_type        state_ff;
   state_type        state_in;
   logic [DIM_W-1:0] fill_ff;
   logic [DIM_W-1:0] fill_in;
   logic [DIM_W-1:0] fill_next;
   logic [DIM_W-1:0] inj_ff;
   logic [DIM_W-1:0] inj_in;
   logic [DIM_W-1:0] rd_ff;
   logic [DIM_W-1:0] rd_in;
   logic             req_fire;
   logic             inject;
   logic             drain_load;
   logic             clear_blk;
   logic             compute_done;
   logic             store_sym;

   // Datapath
   logic [MAX_DIM-1:0][MAX_DIM-1:0][SYM_W-1:0] key_col;
   logic [MAX_DIM-1:0] col_en;
   logic [MAX_DIM-1:0] load_en;
   link_type           chain [MAX_DIM+1];
   res_type            res;
   logic [SYM_W-1:0]   result_ff [MAX_DIM];
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign csr_ready = 1'b1;
   assign key_sel   = csr_index - CSR_KEY_ROW0;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= DIM_W'(1);
         for (int r = 0; r < MAX_DIM; r++) begin
            key_ff[r] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BLOCK_SIZE: begin
               bsize_ff <= csr_data[DIM_W-1:0];
            end
            default: begin
               key_ff[key_sel] <= csr_data;
            end
         endcase
      end
   end

   assign dim    = dim_of(bsize_ff);
   assign dim_m1 = dim - DIM_W'(1);

   // Handshake and sequencing terms
   assign req_fire     = req_valid && req_ready;
   assign store_sym    = req_fire && !req_data.flush && (fill_ff != DIM_W'(MAX_DIM));
   assign fill_next    = store_sym ? fill_ff + DIM_W'(1) : fill_ff;
   assign compute_done = res.valid && (res.row == dim_m1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.flush ? (fill_ff != '0) : (fill_next >= dim)) begin
                  state_in = ST_COMPUTE;
               end
            end
         end
         ST_COMPUTE: begin
            if (compute_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_load && (rd_ff == dim_m1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_ready  = 1'b0;
      inject     = 1'b0;
      drain_load = 1'b0;
      clear_blk  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_COMPUTE: begin
            inject    = (inj_ff < dim);
            clear_blk = compute_done;
         end
         ST_DRAIN: begin
            drain_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Counters
   always_comb begin
      fill_in = fill_next;
      if (clear_blk) begin
         fill_in = '0;
      end
      inj_in = inj_ff;
      if (state_ff == ST_IDLE) begin
         inj_in = '0;
      end else if (inject) begin
         inj_in = inj_ff + DIM_W'(1);
      end
      rd_in = rd_ff;
      if (state_ff == ST_COMPUTE) begin
         rd_in = '0;
      end else if (drain_load) begin
         rd_in = rd_ff + DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         inj_ff   <= '0;
         rd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         inj_ff   <= inj_in;
         rd_ff    <= rd_in;
      end
   end

   // Row sums enter the first cell with a zero accumulator
   assign chain[0].valid = inject;
   assign chain[0].row   = inj_ff;
   assign chain[0].acc   = '0;

   // Cell row, one cell per block column
   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      for (genvar r = 0; r < MAX_DIM; r++) begin : g_key
         assign key_col[c][r] = key_ff[r][c*SYM_W +: SYM_W];
      end
      assign col_en[c]  = (DIM_W'(c) <= dim_m1);
      assign load_en[c] = store_sym && (fill_ff == DIM_W'(c));

      hill37_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .col_en   (col_en[c]),
         .load_en  (load_en[c]),
         .clear_en (clear_blk),
         .load_sym (sym_of_byte(req_data.char_code)),
         .key_col  (key_col[c]),
         .link_in  (chain[c]),
         .link_out (chain[c+1])
      );
   end

   hill37_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .sum_in  (chain[MAX_DIM]),
      .res_out (res)
   );

   // Result store, one symbol per row
   always_ff @(posedge clock) begin
      if (res.valid) begin
         result_ff[res.row] <= res.sym;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (drain_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (drain_load) begin
         rsp_data_ff.cipher_char <= byte_of_sym(result_ff[rd_ff]);
         rsp_data_ff.block_last  <= (rd_ff == dim_m1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (res.row <= dim_m1))
      else $error("row result beyond block size");

   a_done_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPUTE) && compute_done |=> (state_ff == ST_DRAIN))
      else $error("block sums finished but no drain");

   a_idle_chain_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COMPUTE) |-> !res.valid && !chain[MAX_DIM].valid)
      else $error("row sum in flight outside compute");

   a_drain_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rd_ff <= dim_m1))
      else $error("drain index beyond block size");

   a_fill_cleared: assert property (@(posedge clock) disable iff (reset)
      clear_blk |=> (fill_ff == '0))
      else $error("fill count not cleared after block");

endmodule

/* dv/hill_cipher_mod37_encryptor_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_mod37_encryptor_top_test
// Self-checking bench for the mod-37 Hill encryptor. A short directed plan
// covers reset values, the alphabet edges, flush and block-size corner cases.
// Random phases follow: each phase reprograms the block size and key rows
// while the block is idle, then streams text beats in bursts. Every result
// beat is checked against an in-bench cipher model, in order.
// ----------------------------------------------------------------------------
module hill_cipher_mod37_encryptor_top_test;
   import hill37_pkg::*;

   localparam int RANDOM_ITEMS  = 320;
   localparam int SETTLE_CYCLES = 40;    // settle margin after the last expected beat
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_AFTER    = 80;
   localparam int MAX_REPORTS   = 10;
   localparam int PLAN_LEN      = 40;

   localparam logic [KEY_W-1:0] ROW_ALL63 = '1;
   localparam logic [KEY_W-1:0] ROW_ALL36 = 42'h24924924924;
   // columns 0..6 = 36, 1, 0, 63, 37, 2, 5
   localparam logic [KEY_W-1:0] ROW_MIXED = 42'h050A5FC0064;

   typedef enum logic {ROW_REG, ROW_BEAT} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] value;
      req_type          beat;
      logic             typed;
      logic [CHR_W-1:0] typed_char;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index;
   logic [KEY_W-1:0] csr_data;

   hill_cipher_mod37_encryptor_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Cipher model state
   logic [DIM_W-1:0] size_reg;
   logic [KEY_W-1:0] key_reg [MAX_DIM];
   logic [SYM_W-1:0] held_sym [MAX_DIM];
   int               held_cnt;
   rsp_type          cipher_q [$];

   int  mismatches  = 0;
   int  got_cnt     = 0;
   int  idle_cycles = 0;
   int  burst_left;
   int  hold_left   = 0;
   int  rx_cycle    = 0;
   bit  hold_done   = 1'b0;

   plan_row_type plan [PLAN_LEN];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [SYM_W-1:0] plain_sym(input logic [CHR_W-1:0] c);
      if (c >= CHR_A && c <= CHR_Z) return SYM_W'(c - CHR_A);
      if (c >= CHR_ZERO && c <= CHR_NINE) return SYM_W'(c - CHR_ZERO) + SYM_DIGIT0;
      if (c == CHR_SPACE) return SPACE_SYM;
      return '0;
   endfunction

   function automatic logic [CHR_W-1:0] cipher_byte(input logic [SYM_W-1:0] v);
      if (v < SYM_DIGIT0) return CHR_A + CHR_W'(v);
      if (v < SPACE_SYM) return CHR_ZERO + CHR_W'(v - SYM_DIGIT0);
      return CHR_SPACE;
   endfunction

   // Key times block, mod 37, one result beat per row; then empty the block
   function automatic void emit_block(input int n, input logic typed,
                                      input logic [CHR_W-1:0] tchar);
      int      acc;
      rsp_type r;
      for (int k = 0; k < n; k++) begin
         acc = 0;
         for (int j = 0; j < n; j++) begin
            acc = (acc + int'(key_reg[k][SYM_W*j +: SYM_W]) * int'(held_sym[j]))
                  % int'(ALPHA);
         end
         r.cipher_char = typed ? tchar : cipher_byte(SYM_W'(acc));
         r.block_last  = (k == n - 1);
         cipher_q.push_back(r);
      end
      for (int j = 0; j < MAX_DIM; j++) held_sym[j] = SPACE_SYM;
      held_cnt = 0;
   endfunction

   function automatic void take_plaintext(input req_type b, input logic typed,
                                          input logic [CHR_W-1:0] tchar);
      int n;
      n = (size_reg == '0) ? 1 : int'(size_reg);
      if (b.flush) begin
         if (held_cnt != 0) emit_block(n, typed, tchar);
      end else begin
         // a full buffer drops the new symbol but still emits
         if (held_cnt < MAX_DIM) begin
            held_sym[held_cnt] = plain_sym(b.char_code);
            held_cnt++;
         end
         if (held_cnt >= n) emit_block(n, typed, tchar);
      end
   endfunction

   function automatic void report_mismatch(input string what, input rsp_type want,
                                           input rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t mismatch (%s): expected char %h last %b, got char %h last %b",
                  $realtime, what, want.cipher_char, want.block_last,
                  got.cipher_char, got.block_last);
      end
   endfunction

   function automatic plan_row_type reg_row(input logic [IDX_W-1:0] idx,
                                            input logic [KEY_W-1:0] value);
      plan_row_type p;
      p = '0;
      p.kind  = ROW_REG;
      p.idx   = idx;
      p.value = value;
      return p;
   endfunction

   function automatic plan_row_type beat_row(input logic [CHR_W-1:0] ch, input logic fl,
                                             input logic typed,
                                             input logic [CHR_W-1:0] tchar);
      plan_row_type p;
      p = '0;
      p.kind            = ROW_BEAT;
      p.beat.char_code  = ch;
      p.beat.flush      = fl;
      p.typed           = typed;
      p.typed_char      = tchar;
      return p;
   endfunction

   // Register write; caller lowers csr_valid after the last write of a group
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_BLOCK_SIZE) size_reg = value[DIM_W-1:0];
      else key_reg[idx - CSR_KEY_ROW0] = value;
      @(negedge clock);
   endtask

   // One text beat, with burst/gap shaping on the sender side
   task automatic push_beat(input req_type b, input logic typed,
                            input logic [CHR_W-1:0] tchar);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      take_plaintext(b, typed, tchar);
      @(negedge clock);
   endtask

   // Stop sending, wait for every expected beat, then let the block settle
   task automatic drain_wait();
      req_valid <= 1'b0;
      while (cipher_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Receiver: rotating stall pattern plus one long hold-off
   always @(negedge clock) begin
      rx_cycle++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && got_cnt >= HOLD_AFTER && req_valid) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cycle / 64) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (rx_cycle % 3 == 0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Result checker and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            got_cnt++;
            if (cipher_q.size() == 0) begin
               report_mismatch("nothing expected", '0, rsp_data);
            end else begin
               want = cipher_q.pop_front();
               if (want.cipher_char !== rsp_data.cipher_char ||
                   want.block_last !== rsp_data.block_last) begin
                  report_mismatch("wrong beat", want, rsp_data);
               end
            end
         end
      end
   end

   initial begin
      logic             prev_reg;
      logic [DIM_W-1:0] bs;
      logic [KEY_W-1:0] row;
      req_type          b;
      int               pick;
      int               mode;
      int               len;
      int               rand_items;
      bit               first_phase;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      burst_left  = 0;

      // model after reset: block size 1, zero key, empty block of spaces
      size_reg = DIM_W'(1);
      for (int r = 0; r < MAX_DIM; r++) begin
         key_reg[r]  = '0;
         held_sym[r] = SPACE_SYM;
      end
      held_cnt = 0;

      plan = '{
         // zero key: every symbol encrypts to A
         beat_row("A", 1'b0, 1'b1, "A"),
         beat_row(8'hFF, 1'b0, 1'b1, "A"),
         // flush with nothing held
         beat_row(8'h00, 1'b1, 1'b0, 8'h00),
         // identity key, alphabet edges pass through
         reg_row(CSR_KEY_ROW0, 42'd1),
         beat_row("Z", 1'b0, 1'b1, "Z"),
         beat_row("9", 1'b0, 1'b1, "9"),
         beat_row(" ", 1'b0, 1'b1, " "),
         beat_row(8'h80, 1'b0, 1'b1, "A"),
         // block size zero acts as one
         reg_row(CSR_BLOCK_SIZE, 42'd0),
         beat_row("M", 1'b0, 1'b1, "M"),
         // key entry above 36 wraps
         reg_row(CSR_KEY_ROW0, 42'd63),
         beat_row("B", 1'b0, 1'b0, 8'h00),
         // largest block, extreme and mixed key rows
         reg_row(CSR_BLOCK_SIZE, 42'd7),
         reg_row(CSR_KEY_ROW0, ROW_ALL63),
         reg_row(CSR_KEY_ROW0 + 3'd1, ROW_ALL63),
         reg_row(CSR_KEY_ROW0 + 3'd2, ROW_ALL63),
         reg_row(CSR_KEY_ROW0 + 3'd3, ROW_ALL63),
         reg_row(CSR_KEY_ROW0 + 3'd4, ROW_ALL36),
         reg_row(CSR_KEY_ROW0 + 3'd5, 42'd0),
         reg_row(CSR_KEY_ROW0 + 3'd6, ROW_MIXED),
         beat_row("Z", 1'b0, 1'b0, 8'h00),
         beat_row("9", 1'b0, 1'b0, 8'h00),
         beat_row(" ", 1'b0, 1'b0, 8'h00),
         beat_row("A", 1'b0, 1'b0, 8'h00),
         beat_row("0", 1'b0, 1'b0, 8'h00),
         beat_row("Q", 1'b0, 1'b0, 8'h00),
         beat_row(8'h7F, 1'b0, 1'b0, 8'h00),
         // partial block padded by flush
         beat_row("H", 1'b0, 1'b0, 8'h00),
         beat_row("I", 1'b0, 1'b0, 8'h00),
         beat_row(8'h55, 1'b1, 1'b0, 8'h00),
         // shrink the block while symbols are held
         beat_row("C", 1'b0, 1'b0, 8'h00),
         beat_row("D", 1'b0, 1'b0, 8'h00),
         beat_row("E", 1'b0, 1'b0, 8'h00),
         beat_row("F", 1'b0, 1'b0, 8'h00),
         reg_row(CSR_BLOCK_SIZE, 42'd3),
         beat_row("G", 1'b0, 1'b0, 8'h00),
         // flush with more held than the block size
         beat_row("J", 1'b0, 1'b0, 8'h00),
         beat_row("K", 1'b0, 1'b0, 8'h00),
         reg_row(CSR_BLOCK_SIZE, 42'd1),
         beat_row(8'hAA, 1'b1, 1'b0, 8'h00)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed plan
      prev_reg = 1'b1;
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].kind == ROW_REG) begin
            if (!prev_reg) drain_wait();
            write_reg(plan[i].idx, plan[i].value);
            prev_reg = 1'b1;
         end else begin
            if (prev_reg) csr_valid <= 1'b0;
            push_beat(plan[i].beat, plan[i].typed, plan[i].typed_char);
            prev_reg = 1'b0;
         end
      end

      // Random phases: reprogram while idle, then stream text
      rand_items  = 0;
      first_phase = 1'b1;
      while (rand_items < RANDOM_ITEMS) begin
         drain_wait();
         pick = $urandom_range(0, 9);
         if (pick == 0) bs = '0;
         else if (pick == 1) bs = DIM_W'(MAX_DIM);
         else bs = DIM_W'($urandom_range(1, MAX_DIM));
         write_reg(CSR_BLOCK_SIZE, KEY_W'(bs));
         for (int r = 0; r < MAX_DIM; r++) begin
            if (first_phase || $urandom_range(0, 1) == 1) begin
               mode = $urandom_range(0, 9);
               if (mode == 0) row = '0;
               else if (mode == 1) row = '1;
               else begin
                  for (int c = 0; c < MAX_DIM; c++) begin
                     row[SYM_W*c +: SYM_W] = ($urandom_range(0, 7) == 0) ?
                        SYM_W'($urandom_range(37, 63)) : SYM_W'($urandom_range(0, 36));
                  end
               end
               write_reg(CSR_KEY_ROW0 + IDX_W'(r), row);
            end
         end
         csr_valid <= 1'b0;
         first_phase = 1'b0;

         len = $urandom_range(8, 40);
         repeat (len) begin
            pick = $urandom_range(0, 99);
            b.char_code = 8'($urandom_range(0, 255));
            b.flush     = 1'b0;
            // mostly alphabet text, some stray bytes and flushes
            if (pick < 8) b.flush = 1'b1;
            else if (pick >= 16) b.char_code = cipher_byte(SYM_W'($urandom_range(0, 36)));
            push_beat(b, 1'b0, '0);
            rand_items++;
         end
         // flush now and then; otherwise symbols stay held for the next size change
         if ($urandom_range(0, 1) == 1) begin
            b.char_code = 8'($urandom_range(0, 255));
            b.flush     = 1'b1;
            push_beat(b, 1'b0, '0);
            rand_items++;
         end
      end

      drain_wait();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
